// ===== sv/led_breathe_blink_pwm_unit_defines.svh =====
// Assertion macros for the LED pattern unit.
// Used by modules that check their own pipeline; needs clk and arst_n in scope.
`ifndef LED_BREATHE_BLINK_PWM_UNIT_DEFINES_SVH
`define LED_BREATHE_BLINK_PWM_UNIT_DEFINES_SVH

// same-cycle implication
`define LBB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LBB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/lbb_pkg.sv =====
// Shared types and constants of the LED pattern unit.
// No dependencies; imported by every module of the unit.
package lbb_pkg;

	typedef enum logic [1:0] {
		MODE_OFF     = 2'd0,
		MODE_BREATHE = 2'd1,
		MODE_BLINK   = 2'd2
	} lbb_mode_t;

	typedef struct packed {
		logic       breathe;
		logic       blink_on;
		logic [7:0] saw;
	} lbb_ctl_t;

	localparam int TIME_W   = 32;
	localparam int PHASE_W  = 22;
	localparam int RAMP_W   = 21;
	localparam int SCALED_W = 25;
	localparam int LEVEL_W  = 8;
	localparam int WORD_W   = 16;

	localparam logic [31:0] BREATHE_PERIOD = 32'd3000000;
	localparam logic [31:0] BREATHE_HALF   = 32'd1500000;
	localparam logic [31:0] BLINK_HALF     = 32'd100000;
	localparam logic [31:0] PWM_TICK       = 32'd20;

	// reciprocals for quotient estimates, estimate is exact or one low
	localparam logic [21:0] BREATHE_RECIP  = 22'd2932031;
	localparam int          BREATHE_SHIFT  = 43;
	localparam logic [23:0] BLINK_RECIP    = 24'd10995116;
	localparam int          BLINK_SHIFT    = 40;
	localparam logic [31:0] TICK_RECIP     = 32'd3435973836;
	localparam int          TICK_SHIFT     = 36;

	// 255 / 1500000 = 17 / 100000; ceiling reciprocals, exact over the range
	localparam logic [4:0]  LIN_SCALE      = 5'd17;
	localparam logic [25:0] LIN_RECIP      = 26'd43980466;
	localparam int          LIN_SHIFT      = 42;
	localparam logic [16:0] GAMMA_RECIP    = 17'd65794;
	localparam int          GAMMA_SHIFT    = 24;

	localparam logic [7:0]  FULL_LEVEL     = 8'd255;

endpackage

// ===== sv/lbb_phase.sv =====
// Timestamp front end: breathe phase, blink half and PWM sawtooth.
// Four register stages of reciprocal division; depends on lbb_pkg.
module lbb_phase import lbb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic                 in_breathe,
	input  logic [TIME_W-1:0]    time_us,
	output logic                 out_valid,
	output logic [PHASE_W-1:0]   phase,
	output lbb_ctl_t             ctl
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic br_s1, br_s2, br_s3;
	logic [TIME_W-1:0] t_s1, t_s2, t_s3;

	logic [53:0] prod3;
	logic [55:0] prodb;
	logic [63:0] prod20;

	logic [10:0] q3_s2;
	logic [15:0] qb_s2, qb_s3;
	logic [27:0] q20_s2, q20_s3;
	logic [31:0] p3_s3, pb_s3, p20_s3;

	logic [31:0] r3, rb, r20;
	logic [22:0] r3_n;
	logic        b_cor, t_cor;

	logic [PHASE_W-1:0] phase_s4;
	lbb_ctl_t           ctl_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign prod3  = 54'(t_s1) * 54'(BREATHE_RECIP);
	assign prodb  = 56'(t_s1) * 56'(BLINK_RECIP);
	assign prod20 = 64'(t_s1) * 64'(TICK_RECIP);

	assign r3   = t_s3 - p3_s3;
	assign rb   = t_s3 - pb_s3;
	assign r20  = t_s3 - p20_s3;
	assign r3_n = r3[22:0];
	assign b_cor = (rb >= BLINK_HALF);
	assign t_cor = (r20 >= PWM_TICK);

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1   <= time_us;
			br_s1  <= in_breathe;

			t_s2   <= t_s1;
			br_s2  <= br_s1;
			q3_s2  <= prod3[53:BREATHE_SHIFT];
			qb_s2  <= prodb[55:BLINK_SHIFT];
			q20_s2 <= prod20[63:TICK_SHIFT];

			t_s3   <= t_s2;
			br_s3  <= br_s2;
			qb_s3  <= qb_s2;
			q20_s3 <= q20_s2;
			p3_s3  <= 32'(32'(q3_s2) * BREATHE_PERIOD);
			pb_s3  <= 32'(32'(qb_s2) * BLINK_HALF);
			p20_s3 <= 32'(32'(q20_s2) * PWM_TICK);

			phase_s4 <= (r3_n >= 23'(BREATHE_PERIOD)) ?
				PHASE_W'(r3_n - 23'(BREATHE_PERIOD)) : r3_n[PHASE_W-1:0];
			ctl_s4.breathe  <= br_s3;
			ctl_s4.blink_on <= ~(qb_s3[0] ^ b_cor);
			ctl_s4.saw      <= q20_s3[7:0] + {7'd0, t_cor};
		end
	end

	assign out_valid = v_s4;
	assign phase     = phase_s4;
	assign ctl       = ctl_s4;

endmodule

// ===== sv/lbb_gamma.sv =====
// Breathe shaper: triangle ramp, scale to 0..255, square and divide by 255.
// Four register stages; depends on lbb_pkg.
module lbb_gamma import lbb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [PHASE_W-1:0]   phase,
	input  lbb_ctl_t             in_ctl,
	output logic                 out_valid,
	output logic [LEVEL_W-1:0]   level,
	output lbb_ctl_t             out_ctl
);

	logic v_s5, v_s6, v_s7, v_s8;
	lbb_ctl_t ctl_s5, ctl_s6, ctl_s7, ctl_s8;

	logic [RAMP_W-1:0]   ramp;
	logic [SCALED_W-1:0] x_s5;
	logic [50:0]         lin_prod;
	logic [LEVEL_W-1:0]  lin_s6;
	logic [15:0]         sq_s7;
	logic [32:0]         g_prod;
	logic [LEVEL_W-1:0]  lvl_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s5 <= in_valid;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	assign ramp = (phase < PHASE_W'(BREATHE_HALF)) ? phase[RAMP_W-1:0] :
		RAMP_W'(PHASE_W'(BREATHE_PERIOD) - phase);
	assign lin_prod = 51'(x_s5) * 51'(LIN_RECIP);
	assign g_prod   = 33'(sq_s7) * 33'(GAMMA_RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s5   <= SCALED_W'(ramp) * SCALED_W'(LIN_SCALE);
			ctl_s5 <= in_ctl;

			lin_s6 <= lin_prod[LIN_SHIFT+LEVEL_W-1:LIN_SHIFT];
			ctl_s6 <= ctl_s5;

			sq_s7  <= 16'(lin_s6) * 16'(lin_s6);
			ctl_s7 <= ctl_s6;

			lvl_s8 <= g_prod[GAMMA_SHIFT+LEVEL_W-1:GAMMA_SHIFT];
			ctl_s8 <= ctl_s7;
		end
	end

	assign out_valid = v_s8;
	assign level     = lvl_s8;
	assign out_ctl   = ctl_s8;

endmodule

// ===== sv/led_breathe_blink_pwm_unit.sv =====
// LED pattern unit: takes one microsecond timestamp per word and returns the
// pattern brightness and the PWM-sampled LED level. One word enters per clock
// while the skid register is empty; a result passes the eight register stages
// of reciprocal division, ramp scaling and squaring, then the output register.
// With the pattern off a timestamp is taken and gives no word. When the output
// is held, one more result moves into a skid register, then the whole pipeline
// holds. The user must write pattern_mode only while idle; it is unchecked.
`include "led_breathe_blink_pwm_unit_defines.svh"

module led_breathe_blink_pwm_unit import lbb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data,       // pattern_mode
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // time_us[31:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata    // led_on[0], brightness[8:1], zero[15:9]
);

	logic [1:0] mode_q;
	logic       en;
	logic       take;
	logic       in_valid;
	logic       in_breathe;

	logic                ph_valid;
	logic [PHASE_W-1:0]  ph_phase;
	lbb_ctl_t            ph_ctl;

	logic                g_valid;
	logic [LEVEL_W-1:0]  g_level;
	lbb_ctl_t            g_ctl;

	logic [LEVEL_W-1:0]  level;
	logic                led;
	logic [WORD_W-1:0]   word;
	logic                push;

	logic                out_v_q, skid_v_q;
	logic [WORD_W-1:0]   out_data_q, skid_data_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_OFF;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	assign en            = ~skid_v_q;
	assign s_axis_tready = en;
	assign take          = s_axis_tvalid & s_axis_tready;
	assign in_valid      = take & (mode_q != MODE_OFF);
	assign in_breathe    = (mode_q == MODE_BREATHE);

	lbb_phase u_phase (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (in_valid),
		.in_breathe (in_breathe),
		.time_us    (s_axis_tdata),
		.out_valid  (ph_valid),
		.phase      (ph_phase),
		.ctl        (ph_ctl)
	);

	lbb_gamma u_gamma (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (ph_valid),
		.phase     (ph_phase),
		.in_ctl    (ph_ctl),
		.out_valid (g_valid),
		.level     (g_level),
		.out_ctl   (g_ctl)
	);

	assign level = g_ctl.breathe ? g_level : (g_ctl.blink_on ? FULL_LEVEL : '0);
	assign led   = (level > g_ctl.saw);
	assign word  = {{(WORD_W-LEVEL_W-1){1'b0}}, level, led};
	assign push  = en & g_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (m_axis_tready || !out_v_q) begin
			out_v_q  <= skid_v_q | push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_axis_tready || !out_v_q) begin
			out_data_q <= skid_v_q ? skid_data_q : word;
		end else if (push) begin
			skid_data_q <= word;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_data_q;

	`LBB_ASSERT_NOW(a_skid_behind_out, skid_v_q, out_v_q, "skid word without output word")
	`LBB_ASSERT_NEXT(a_skid_drains, out_v_q && m_axis_tready && skid_v_q,
		out_v_q && out_data_q == $past(skid_data_q), "skid word lost on drain")
	`LBB_ASSERT_NOW(a_lit_needs_level, out_v_q && out_data_q[0],
		out_data_q[LEVEL_W:1] != '0, "LED lit at zero brightness")
	`LBB_ASSERT_NOW(a_blink_full_or_dark, push && !g_ctl.breathe,
		level == FULL_LEVEL || level == '0, "blink level neither full nor dark")

endmodule
